>>> sv/ssfr_pkg.sv
package ssfr_pkg;

  typedef enum logic [1:0] {
    OP_LOAD_W = 2'd0,
    OP_LOAD_H = 2'd1,
    OP_NONZERO = 2'd2,
    OP_UNUSED = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_DIV,
    ST_DONE
  } state_t;

  localparam int unsigned RankRegW = 5;
  localparam int unsigned RankResetVal = 16;
  localparam int unsigned IdxW = 10;
  localparam int unsigned DataW = 32;
  localparam int unsigned AccW = 64;
  localparam int unsigned MaxRows = 1024;
  localparam int unsigned MaxCols = 1024;
  localparam int unsigned MaxRank = 16;

endpackage

>>> sv/ssfr_front.sv
module ssfr_front #(
  parameter int unsigned QDEPTH = 2
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_push,
  output logic                           in_full,
  input  logic [1:0]                     in_operation,
  input  logic [ssfr_pkg::IdxW-1:0]      in_row,
  input  logic [ssfr_pkg::IdxW-1:0]      in_col,
  input  logic [3:0]                     in_rank_index,
  input  logic signed [ssfr_pkg::DataW-1:0] in_value,
  input  logic                           back_busy,
  output logic                           w_we,
  output logic                           h_we,
  output logic [ssfr_pkg::IdxW-1:0]      ld_row,
  output logic [ssfr_pkg::IdxW-1:0]      ld_col,
  output logic [3:0]                     ld_k,
  output logic signed [ssfr_pkg::DataW-1:0] ld_value,
  output logic                           nz_valid,
  input  logic                           nz_take,
  output logic [ssfr_pkg::IdxW-1:0]      nz_row,
  output logic [ssfr_pkg::IdxW-1:0]      nz_col,
  output logic signed [ssfr_pkg::DataW-1:0] nz_value
);
  localparam int unsigned PtrW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

  logic [ssfr_pkg::IdxW-1:0] q_row_r [QDEPTH];
  logic [ssfr_pkg::IdxW-1:0] q_col_r [QDEPTH];
  logic signed [ssfr_pkg::DataW-1:0] q_val_r [QDEPTH];
  logic [PtrW-1:0] wp_r, rp_r;
  logic [PtrW:0] cnt_r;
  logic acc, is_nz, is_load, do_pop;

  // loads bypass the queue; nonzeros queue up for the back end
  // a load waits until no earlier nonzero is queued or still in work in the back end
  assign is_load = (in_operation == ssfr_pkg::OP_LOAD_W)
    || (in_operation == ssfr_pkg::OP_LOAD_H);
  assign in_full = (cnt_r == QDEPTH[PtrW:0]) || (is_load && (nz_valid || back_busy));
  assign acc = in_push && !in_full;
  assign is_nz = acc && (in_operation == ssfr_pkg::OP_NONZERO);
  assign w_we = acc && (in_operation == ssfr_pkg::OP_LOAD_W)
    && ({22'd0, in_row} < ssfr_pkg::MaxRows) && ({28'd0, in_rank_index} < ssfr_pkg::MaxRank);
  assign h_we = acc && (in_operation == ssfr_pkg::OP_LOAD_H)
    && ({22'd0, in_col} < ssfr_pkg::MaxCols) && ({28'd0, in_rank_index} < ssfr_pkg::MaxRank);
  assign ld_row = in_row;
  assign ld_col = in_col;
  assign ld_k = in_rank_index;
  assign ld_value = in_value;

  assign nz_valid = (cnt_r != '0);
  assign do_pop = nz_take && nz_valid;
  assign nz_row = q_row_r[rp_r];
  assign nz_col = q_col_r[rp_r];
  assign nz_value = q_val_r[rp_r];

  always_ff @(posedge clk) begin
    if (is_nz) begin
      q_row_r[wp_r] <= in_row;
      q_col_r[wp_r] <= in_col;
      q_val_r[wp_r] <= in_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (is_nz) wp_r <= (wp_r == PtrW'(QDEPTH - 1)) ? '0 : wp_r + 1'b1;
      if (do_pop) rp_r <= (rp_r == PtrW'(QDEPTH - 1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + {{PtrW{1'b0}}, is_nz} - {{PtrW{1'b0}}, do_pop};
    end
  end
endmodule

>>> sv/ssfr_div.sv
module ssfr_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [95:0] num,
  input  logic [63:0] den,
  output logic        busy,
  output logic [95:0] quo
);
  // restoring divider, one quotient bit per cycle, unsigned magnitudes
  logic [95:0] q_r, q_nxt;
  logic [64:0] rem_r, rem_nxt;
  logic [63:0] d_r;
  logic [6:0]  cnt_r;
  logic [64:0] sh, diff;

  assign busy = (cnt_r != '0);
  assign quo = q_r;
  assign sh = {rem_r[63:0], q_r[95]};
  assign diff = sh - {1'b0, d_r};

  always_comb begin
    rem_nxt = diff[64] ? sh : diff;
    q_nxt = {q_r[94:0], ~diff[64]};
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r <= num;
      rem_r <= '0;
      d_r <= den;
    end else if (busy) begin
      q_r <= q_nxt;
      rem_r <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) cnt_r <= '0;
    else if (start) cnt_r <= 7'd96;
    else if (busy) cnt_r <= cnt_r - 1'b1;
  end
endmodule

>>> sv/ssfr_back.sv
module ssfr_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [ssfr_pkg::RankRegW-1:0]  rank_reg,
  input  logic                           w_we,
  input  logic                           h_we,
  input  logic [ssfr_pkg::IdxW-1:0]      ld_row,
  input  logic [ssfr_pkg::IdxW-1:0]      ld_col,
  input  logic [3:0]                     ld_k,
  input  logic signed [ssfr_pkg::DataW-1:0] ld_value,
  input  logic                           nz_valid,
  output logic                           nz_take,
  output logic                           back_busy,
  input  logic [ssfr_pkg::IdxW-1:0]      nz_row,
  input  logic [ssfr_pkg::IdxW-1:0]      nz_col,
  input  logic signed [ssfr_pkg::DataW-1:0] nz_value,
  output logic                           out_empty,
  input  logic                           out_pop,
  output logic signed [ssfr_pkg::DataW-1:0] out_ratio,
  output logic                           out_zero_denominator,
  output logic                           out_saturated
);
  localparam int unsigned KW = (ssfr_pkg::MaxRank > 1) ? $clog2(ssfr_pkg::MaxRank) : 1;
  localparam int unsigned RW = (ssfr_pkg::MaxRows > 1) ? $clog2(ssfr_pkg::MaxRows) : 1;
  localparam int unsigned CW = (ssfr_pkg::MaxCols > 1) ? $clog2(ssfr_pkg::MaxCols) : 1;
  localparam int unsigned KCW = $clog2(ssfr_pkg::MaxRank + 1);

  logic signed [31:0] w_mem [ssfr_pkg::MaxRows * ssfr_pkg::MaxRank];
  logic signed [31:0] h_mem [ssfr_pkg::MaxCols * ssfr_pkg::MaxRank];
  logic signed [31:0] w_rd_r, h_rd_r;

  ssfr_pkg::state_t st_r, st_nxt;
  logic [KCW-1:0] rank_r, kcnt_r;
  logic [RW-1:0] row_r;
  logic [CW-1:0] col_r;
  logic inrange_r, rd_v_r, prod_v_r;
  logic signed [31:0] x_r;
  logic signed [63:0] prod_r, acc_r;
  logic signed [ssfr_pkg::DataW-1:0] res_r;
  logic zd_r, sat_r, full_r;
  logic div_start, div_busy, started_r;
  logic [95:0] div_q;
  logic [63:0] dmag;
  logic [95:0] nmag;
  logic neg;
  logic [KCW-1:0] rank_eff;
  logic [KW-1:0] kidx;

  always_comb begin
    if (rank_reg == '0) rank_eff = KCW'(1);
    else if ({27'd0, rank_reg} > ssfr_pkg::MaxRank) rank_eff = KCW'(ssfr_pkg::MaxRank);
    else rank_eff = KCW'(rank_reg);
  end

  assign kidx = kcnt_r[KW-1:0];
  assign back_busy = (st_r != ssfr_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (w_we) w_mem[{ld_row[RW-1:0], ld_k[KW-1:0]}] <= ld_value;
    if (h_we) h_mem[{ld_col[CW-1:0], ld_k[KW-1:0]}] <= ld_value;
    w_rd_r <= w_mem[{row_r, kidx}];
    h_rd_r <= h_mem[{col_r, kidx}];
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ssfr_pkg::ST_IDLE:  if (nz_valid) st_nxt = ssfr_pkg::ST_MAC;
      ssfr_pkg::ST_MAC:   if (kcnt_r == rank_r - 1'b1) st_nxt = ssfr_pkg::ST_DRAIN;
      // hold the new quotient back until the previous result is taken
      ssfr_pkg::ST_DRAIN: if (!rd_v_r && !prod_v_r && !full_r) st_nxt = ssfr_pkg::ST_DIV;
      ssfr_pkg::ST_DIV:   if (started_r && !div_busy) st_nxt = ssfr_pkg::ST_DONE;
      ssfr_pkg::ST_DONE:  if (!full_r) st_nxt = ssfr_pkg::ST_IDLE;
      default:            st_nxt = ssfr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    nz_take = 1'b0;
    div_start = 1'b0;
    unique case (st_r)
      ssfr_pkg::ST_IDLE: nz_take = nz_valid;
      ssfr_pkg::ST_DIV:  div_start = !started_r && (acc_r != '0);
      default: ;
    endcase
  end

  assign neg = x_r[31] ^ acc_r[63];
  assign dmag = acc_r[63] ? 64'(-acc_r) : acc_r;
  assign nmag = {32'd0, (x_r[31] ? 32'(-x_r) : x_r), 32'd0} >> 16;

  ssfr_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(nmag), .den(dmag),
    .busy(div_busy), .quo(div_q)
  );

  always_ff @(posedge clk) begin
    prod_r <= 64'(w_rd_r) * 64'(h_rd_r);
    if (st_r == ssfr_pkg::ST_IDLE && nz_valid) begin
      row_r <= nz_row[RW-1:0];
      col_r <= nz_col[CW-1:0];
      inrange_r <= ({22'd0, nz_row} < ssfr_pkg::MaxRows)
        && ({22'd0, nz_col} < ssfr_pkg::MaxCols);
      x_r <= nz_value;
      rank_r <= rank_eff;
      acc_r <= '0;
    end else if (prod_v_r && inrange_r) begin
      acc_r <= acc_r + (prod_r >>> 16);
    end
    // sign-correct and clamp once the divider finishes; a zero denominator gives a clamped result
    if (st_r == ssfr_pkg::ST_DIV && started_r && !div_busy && acc_r != '0) begin
      zd_r <= 1'b0;
      if (!neg) begin
        sat_r <= (div_q > 96'h7FFFFFFF);
        res_r <= (div_q > 96'h7FFFFFFF) ? 32'h7FFFFFFF : div_q[31:0];
      end else begin
        sat_r <= (div_q > 96'h80000000);
        res_r <= (div_q > 96'h80000000) ? 32'h80000000 : 32'(-div_q[31:0]);
      end
    end else if (st_r == ssfr_pkg::ST_DIV && !started_r && acc_r == '0) begin
      zd_r <= 1'b1;
      sat_r <= 1'b0;
      res_r <= x_r[31] ? 32'h80000000 : 32'h7FFFFFFF;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ssfr_pkg::ST_IDLE;
      kcnt_r <= '0;
      rd_v_r <= 1'b0;
      prod_v_r <= 1'b0;
      started_r <= 1'b0;
      full_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      rd_v_r <= (st_r == ssfr_pkg::ST_MAC);
      prod_v_r <= rd_v_r;
      if (st_r == ssfr_pkg::ST_MAC) kcnt_r <= kcnt_r + 1'b1;
      else kcnt_r <= '0;
      if (st_r == ssfr_pkg::ST_DIV) started_r <= 1'b1;
      else started_r <= 1'b0;
      if (st_r == ssfr_pkg::ST_DONE && !full_r) full_r <= 1'b1;
      else if (out_pop && full_r) full_r <= 1'b0;
    end
  end

  // zero denominator result is ready the first div cycle; treat as done
  assign out_empty = !full_r;
  assign out_ratio = res_r;
  assign out_zero_denominator = zd_r;
  assign out_saturated = sat_r;
endmodule

>>> sv/sparse_sampled_factor_ratio_top.sv
// per nonzero, from acceptance to a waiting result: one read of each store per factor, a drain
// of the read and product registers, the divider (skipped when the dot product is zero) and the
// handoff to the output; a result not yet popped holds the next one before the divider
// one nonzero in work at a time, the next taken once the back end is idle; nonzeros wait in
// a 2-entry queue, loads are written on acceptance but wait while an earlier nonzero is queued or in work
// rst_n is synchronous, active low; rank_in_use resets to 16; stores are not cleared
module sparse_sampled_factor_ratio_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [1:0]  in_operation,
  input  logic [9:0]  in_row,
  input  logic [9:0]  in_col,
  input  logic [3:0]  in_rank_index,
  input  logic signed [31:0] in_value,
  output logic        out_empty,
  input  logic        out_pop,
  output logic signed [31:0] out_ratio,
  output logic        out_zero_denominator,
  output logic        out_saturated,
  input  logic        cfg_we,
  input  logic [4:0]  cfg_wdata
);
  logic [4:0] rank_r;
  logic w_we, h_we, nz_valid, nz_take, back_busy;
  logic [9:0] ld_row, ld_col, nz_row, nz_col;
  logic [3:0] ld_k;
  logic signed [31:0] ld_value, nz_value;

  always_ff @(posedge clk) begin
    if (!rst_n) rank_r <= 5'(ssfr_pkg::RankResetVal);
    else if (cfg_we) rank_r <= cfg_wdata;
  end

  ssfr_front u_front (
    .clk(clk), .rst_n(rst_n), .in_push(in_push), .in_full(in_full),
    .in_operation(in_operation), .in_row(in_row), .in_col(in_col),
    .in_rank_index(in_rank_index), .in_value(in_value), .back_busy(back_busy),
    .w_we(w_we), .h_we(h_we), .ld_row(ld_row), .ld_col(ld_col), .ld_k(ld_k),
    .ld_value(ld_value), .nz_valid(nz_valid), .nz_take(nz_take),
    .nz_row(nz_row), .nz_col(nz_col), .nz_value(nz_value)
  );

  ssfr_back u_back (
    .clk(clk), .rst_n(rst_n), .rank_reg(rank_r),
    .w_we(w_we), .h_we(h_we), .ld_row(ld_row), .ld_col(ld_col), .ld_k(ld_k),
    .ld_value(ld_value), .nz_valid(nz_valid), .nz_take(nz_take), .back_busy(back_busy),
    .nz_row(nz_row), .nz_col(nz_col), .nz_value(nz_value),
    .out_empty(out_empty), .out_pop(out_pop), .out_ratio(out_ratio),
    .out_zero_denominator(out_zero_denominator), .out_saturated(out_saturated)
  );
endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned RANKS = 16;
  localparam int unsigned CYCLE_LIMIT = 3000000;
  localparam int unsigned SETTLE_CYCLES = 200;

  typedef struct {
    ssfr_pkg::op_t      op;
    logic [9:0]         row;
    logic [9:0]         col;
    logic [3:0]         k;
    logic signed [31:0] value;
  } job_t;

  typedef struct {
    logic signed [31:0] ratio;
    logic               zero_den;
    logic               sat;
  } quotient_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_push = 1'b0;
  logic               in_full;
  logic [1:0]         in_operation = '0;
  logic [9:0]         in_row = '0;
  logic [9:0]         in_col = '0;
  logic [3:0]         in_rank_index = '0;
  logic signed [31:0] in_value = '0;
  logic               out_empty;
  logic               out_pop = 1'b0;
  logic signed [31:0] out_ratio;
  logic               out_zero_denominator;
  logic               out_saturated;
  logic               cfg_we = 1'b0;
  logic [4:0]         cfg_wdata = '0;

  // predictor state
  logic signed [31:0] w_mem [RANKS*1024];
  logic signed [31:0] h_mem [RANKS*1024];
  logic [4:0]         rank_reg = 5'd16;

  job_t      pending_items[$];
  quotient_t quotients_due[$];
  job_t      cur;
  int        send_gap = 0;
  int        pop_gap = 0;
  bit        no_idle = 1'b0;
  int        errors = 0;
  int        mismatches = 0;
  int        n_loads = 0;
  int        n_quotients = 0;
  int        n_zero_den = 0;
  int        n_sat = 0;
  int unsigned cycles = 0;

  // rows and columns whose factors are all written; nonzeros only use these
  logic [9:0] row_ids [8] = '{10'd0, 10'd1, 10'd2, 10'd3, 10'd1023, 10'd682, 10'd341, 10'd512};
  logic [9:0] col_ids [8] = '{10'd0, 10'd1, 10'd2, 10'd1023, 10'd3, 10'd365, 10'd658, 10'd128};
  logic [4:0] ranks [8] = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd17, 5'd8, 5'd15, 5'd3};

  sparse_sampled_factor_ratio_top u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full),
    .in_operation(in_operation), .in_row(in_row), .in_col(in_col),
    .in_rank_index(in_rank_index), .in_value(in_value),
    .out_empty(out_empty), .out_pop(out_pop),
    .out_ratio(out_ratio), .out_zero_denominator(out_zero_denominator),
    .out_saturated(out_saturated),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always #2 clk = ~clk;

  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic signed [31:0] rand_value();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return '0;
      3: return $signed(32'($urandom_range(0, 131072)) - 32'd65536);
      default: return $signed(32'($urandom));
    endcase
  endfunction

  task automatic apply_item(input job_t j);
    int unsigned n;
    longint d;
    longint q;
    quotient_t res;
    d = 0;
    case (j.op)
      ssfr_pkg::OP_LOAD_W: begin
        w_mem[j.row*RANKS + j.k] = j.value;
        n_loads++;
      end
      ssfr_pkg::OP_LOAD_H: begin
        h_mem[j.col*RANKS + j.k] = j.value;
        n_loads++;
      end
      ssfr_pkg::OP_NONZERO: begin
        n = (rank_reg == 0) ? 1 : (rank_reg > RANKS) ? RANKS : rank_reg;
        for (int i = 0; i < n; i++)
          d += (longint'(w_mem[j.row*RANKS + i]) * longint'(h_mem[j.col*RANKS + i])) >>> 16;
        res.zero_den = 1'b0;
        res.sat = 1'b0;
        if (d == 0) begin
          res.zero_den = 1'b1;
          q = (j.value >= 0) ? 64'sd2147483647 : -64'sd2147483648;
        end else begin
          q = (longint'(j.value) * 65536) / d;
          if (q > 64'sd2147483647) begin
            q = 64'sd2147483647;
            res.sat = 1'b1;
          end else if (q < -64'sd2147483648) begin
            q = -64'sd2147483648;
            res.sat = 1'b1;
          end
        end
        res.ratio = q[31:0];
        quotients_due.push_back(res);
        n_quotients++;
        if (res.zero_den) n_zero_den++;
        if (res.sat) n_sat++;
      end
      default: ;
    endcase
  endtask

  // driver
  always @(posedge clk) begin
    logic go;
    go = in_push;
    if (rst_n) begin
      if (in_push && !in_full) begin
        apply_item(cur);
        go = 1'b0;
        send_gap = rand_gap();
      end
      if (!go) begin
        if (send_gap > 0) send_gap--;
        else if (pending_items.size() > 0) begin
          cur = pending_items.pop_front();
          go = 1'b1;
        end
      end
    end
    in_push <= go;
    in_operation <= cur.op;
    in_row <= cur.row;
    in_col <= cur.col;
    in_rank_index <= cur.k;
    in_value <= cur.value;
  end

  // monitor
  always @(posedge clk) begin
    quotient_t exp_q;
    logic pop_next;
    pop_next = 1'b0;
    if (rst_n) begin
      if (out_pop && !out_empty) begin
        if (quotients_due.size() == 0) begin
          errors++;
          if (mismatches++ < 10)
            $display("unexpected item: ratio %0d zd %0b sat %0b",
                     out_ratio, out_zero_denominator, out_saturated);
        end else begin
          exp_q = quotients_due.pop_front();
          if (out_ratio !== exp_q.ratio || out_zero_denominator !== exp_q.zero_den ||
              out_saturated !== exp_q.sat) begin
            errors++;
            if (mismatches++ < 10)
              $display("mismatch: exp ratio %0d zd %0b sat %0b, got ratio %0d zd %0b sat %0b",
                       exp_q.ratio, exp_q.zero_den, exp_q.sat,
                       out_ratio, out_zero_denominator, out_saturated);
          end
        end
        pop_gap = rand_gap();
      end
      if (pop_gap > 0) pop_gap--;
      else pop_next = 1'b1;
    end
    out_pop <= pop_next;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb: failure");
      $finish;
    end
  end

  task automatic push_item(input ssfr_pkg::op_t op, input logic [9:0] r, input logic [9:0] c,
                           input logic [3:0] k, input logic signed [31:0] v);
    job_t j;
    j.op = op;
    j.row = r;
    j.col = c;
    j.k = k;
    j.value = v;
    pending_items.push_back(j);
  endtask

  // wait until everything sent is accepted and every quotient has come back
  task automatic drain();
    int quiet;
    quiet = 0;
    while (quiet < 3) begin
      @(posedge clk);
      if (pending_items.size() == 0 && !in_push && quotients_due.size() == 0) quiet++;
      else quiet = 0;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    while (quotients_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_rank(input logic [4:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    rank_reg = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_phase(input int count);
    int r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 15)
        push_item(ssfr_pkg::OP_LOAD_W, 10'($urandom), '0, 4'($urandom), rand_value());
      else if (r < 30)
        push_item(ssfr_pkg::OP_LOAD_H, '0, 10'($urandom), 4'($urandom), rand_value());
      else if (r < 35)
        // rewrite a factor of a tracked row or column
        push_item(ssfr_pkg::OP_LOAD_W, row_ids[$urandom_range(0, 7)],
                  col_ids[$urandom_range(0, 7)], 4'($urandom), rand_value());
      else if (r < 40)
        push_item(ssfr_pkg::OP_LOAD_H, row_ids[$urandom_range(0, 7)],
                  col_ids[$urandom_range(0, 7)], 4'($urandom), rand_value());
      else if (r < 95)
        push_item(ssfr_pkg::OP_NONZERO, row_ids[$urandom_range(0, 7)],
                  col_ids[$urandom_range(0, 7)], 4'($urandom), rand_value());
      else begin
        push_item(ssfr_pkg::OP_UNUSED, 10'($urandom), 10'($urandom), 4'($urandom),
                  rand_value());
        i--;
      end
    end
  endtask

  initial begin
    logic signed [31:0] w_v;
    logic signed [31:0] h_v;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // factor setup: zero row, all -1 row, extreme rows, then random content
    for (int i = 0; i < 8; i++)
      for (int k = 0; k < RANKS; k++) begin
        case (i)
          0: w_v = '0;
          1: w_v = -32'sd1;
          2: w_v = 32'sh7fffffff;
          3: w_v = 32'sh80000000;
          default: w_v = rand_value();
        endcase
        case (i)
          0: h_v = 32'sd1;
          1: h_v = 32'sh80000000;
          2: h_v = 32'sh7fffffff;
          3: h_v = 32'sd65536;
          default: h_v = rand_value();
        endcase
        push_item(ssfr_pkg::OP_LOAD_W, row_ids[i], 10'($urandom), 4'(k), w_v);
        push_item(ssfr_pkg::OP_LOAD_H, 10'($urandom), col_ids[i], 4'(k), h_v);
      end

    // directed: zero denominator, tiny negative denominator, extremes of x
    push_item(ssfr_pkg::OP_NONZERO, row_ids[0], col_ids[2], '0, 32'sd5);
    push_item(ssfr_pkg::OP_NONZERO, row_ids[0], col_ids[2], '0, -32'sd5);
    push_item(ssfr_pkg::OP_NONZERO, row_ids[0], col_ids[0], '0, '0);
    push_item(ssfr_pkg::OP_NONZERO, row_ids[1], col_ids[0], '0, 32'sh7fffffff);
    push_item(ssfr_pkg::OP_NONZERO, row_ids[1], col_ids[0], '0, 32'sh80000000);
    push_item(ssfr_pkg::OP_NONZERO, row_ids[1], col_ids[1], '0, 32'sh7fffffff);
    push_item(ssfr_pkg::OP_NONZERO, row_ids[2], col_ids[2], '0, 32'sh80000000);
    push_item(ssfr_pkg::OP_NONZERO, row_ids[3], col_ids[1], '0, 32'sh7fffffff);
    push_item(ssfr_pkg::OP_NONZERO, row_ids[3], col_ids[2], '0, -32'sd1);
    push_item(ssfr_pkg::OP_NONZERO, row_ids[2], col_ids[3], '0, 32'sd65536);
    push_item(ssfr_pkg::OP_NONZERO, row_ids[3], col_ids[3], '0, 32'sh80000000);
    push_item(ssfr_pkg::OP_NONZERO, row_ids[4], col_ids[7], '0, 32'sd1);
    push_item(ssfr_pkg::OP_UNUSED, 10'h3ff, 10'h3ff, 4'hf, 32'shffffffff);
    push_item(ssfr_pkg::OP_NONZERO, 10'd1023, 10'd1023, 4'hf, -32'sd1);
    drain();

    for (int p = 0; p < 8; p++) begin
      if (p > 0) write_rank(ranks[p]);
      no_idle = (p % 3 == 1);
      random_phase(40);
      // pause the sender until everything has come back
      drain();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    errors += quotients_due.size();
    $display("covered %0d factor loads and %0d quotients over 8 rank settings",
             n_loads, n_quotients);
    $display("%0d zero denominators, %0d clamped quotients, %0d errors",
             n_zero_den, n_sat, errors);
    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
